// File: rtl/phpd_pkg.sv
`timescale 1ns / 1ps

package phpd_pkg;

    // field widths
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned SYNC_W  = 60;
    localparam int unsigned TIME_W  = 63;
    localparam int unsigned COL_W   = 8;
    localparam int unsigned ROW_W   = 8;
    localparam int unsigned TOT_W   = 10;

    typedef logic [3:0] nibble_t;

    // packet header codes, bits 63..60
    localparam nibble_t HDR_HEARTBEAT = 4'h4;
    localparam nibble_t HDR_PIXEL_A   = 4'hA;
    localparam nibble_t HDR_PIXEL_B   = 4'hB;

    // heartbeat sub-header codes, bits 59..56
    localparam nibble_t SUB_SYNC_LOW  = 4'h4;
    localparam nibble_t SUB_SYNC_HIGH = 4'h5;

    // sync time below which hits are decoded, after reset
    localparam logic [SYNC_W-1:0] STARTUP_LIMIT_RESET = 60'd983040000000;

    // wrap correction constants
    localparam logic [TIME_W-1:0] HALF_WRAP     = 63'h000_0200_0000_0000;
    localparam logic [TIME_W-1:0] HALF_WRAP_M1  = 63'h000_01FF_FFFF_FFFF;
    localparam logic [TIME_W-1:0] TIME_MAX      = {TIME_W{1'b1}};

endpackage

// File: rtl/pixel_hit_packet_decoder.sv
`timescale 1ns / 1ps

// pixel hit packet decoder
//
// input channel: packet_word with in_valid / in_ready, one 64-bit readout
// packet per transaction. output channel: hit_column, hit_row, tot_count and
// hit_time with out_valid / out_ready, one hit per pixel packet once started.
// configuration: startup_limit is written at any edge with cfg_wr_en high;
// the user must write it only while the block is idle; the block does not check this.
//
// a packet accepted into the input register is decoded there and its hit is
// loaded into the result register. throughput: one packet per cycle while the
// receiver takes hits; the single decode stage (timestamp build, 63-bit wrap
// subtract, upper add, saturation) sets this: the previous hit time feeds the next.
// heartbeats and ignored packets pass without using the output slot.
//
// reset: sync time, previous hit time and the start flag clear, the limit
// returns to 983040000000, both stages empty.
// receiver stall: the hit register holds; heartbeats and ignored packets keep
// flowing, the next pixel packet waits in the input register and in_ready
// drops until out_ready returns.

module pixel_hit_packet_decoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [phpd_pkg::SYNC_W-1:0]         startup_limit,
    // packet input
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [phpd_pkg::WORD_W-1:0]         packet_word,
    // hit output
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [phpd_pkg::COL_W-1:0]          hit_column,
    output logic [phpd_pkg::ROW_W-1:0]          hit_row,
    output logic [phpd_pkg::TOT_W-1:0]          tot_count,
    output logic [phpd_pkg::TIME_W-1:0]         hit_time
);

    // input register
    logic                               in_valid_reg;
    logic [phpd_pkg::WORD_W-1:0]        packet_reg;

    // block state
    logic [phpd_pkg::SYNC_W-1:0]        limit_reg;
    logic [phpd_pkg::SYNC_W-1:0]        sync_reg;
    logic [phpd_pkg::SYNC_W-1:0]        sync_next;
    logic [phpd_pkg::TIME_W-1:0]        prev_reg;
    logic                               started_reg;
    logic                               started_next;

    // result register
    logic                               out_valid_reg;
    logic [phpd_pkg::COL_W-1:0]         col_reg;
    logic [phpd_pkg::ROW_W-1:0]         row_reg;
    logic [phpd_pkg::TOT_W-1:0]         tot_reg;
    logic [phpd_pkg::TIME_W-1:0]        time_reg;

    // decode
    phpd_pkg::nibble_t                  hdr;
    phpd_pkg::nibble_t                  sub;
    logic                               is_beat;
    logic                               is_hit;
    logic                               advance;
    logic [phpd_pkg::SYNC_W-1:0]        sync_low_upd;
    logic [phpd_pkg::SYNC_W-1:0]        sync_high_upd;
    logic [phpd_pkg::SYNC_W-1:0]        t_raw;
    logic [phpd_pkg::TIME_W-1:0]        t_ext;
    logic [phpd_pkg::TIME_W-1:0]        diff;
    logic                               behind;
    logic [phpd_pkg::WORD_W-1:0]        bump;
    logic [21:0]                        wraps;
    logic [22:0]                        upper;
    logic [phpd_pkg::TIME_W-1:0]        t_fin;
    logic [phpd_pkg::COL_W-1:0]         col_calc;
    logic [phpd_pkg::ROW_W-1:0]         row_calc;

    assign hdr     = packet_reg[63:60];
    assign sub     = packet_reg[59:56];
    assign is_beat = (hdr == phpd_pkg::HDR_HEARTBEAT) && (packet_reg[55:48] == 8'h00);
    assign is_hit  = started_reg && (hdr inside {phpd_pkg::HDR_PIXEL_A, phpd_pkg::HDR_PIXEL_B});

    // the packet leaves the input register unless it is a hit blocked by a full slot
    assign advance  = in_valid_reg && (!is_hit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // heartbeat updates of the sync time
    assign sync_low_upd  = {sync_reg[59:44], packet_reg[47:16], 12'h000};
    assign sync_high_upd = {packet_reg[31:16], sync_reg[43:0]};

    always_comb
    begin
        sync_next    = sync_reg;
        started_next = started_reg;
        if (is_beat)
        begin
            case (sub)
                phpd_pkg::SUB_SYNC_LOW:
                begin
                    sync_next = sync_low_upd;
                end
                phpd_pkg::SUB_SYNC_HIGH:
                begin
                    sync_next = sync_high_upd;
                    if (sync_high_upd < limit_reg)
                    begin
                        started_next = 1'b1;
                    end
                end
                default:
                begin
                    sync_next = sync_reg;
                end
            endcase
        end
    end

    // column and row: double column * 2 + pixel / 4, super pixel * 4 + pixel % 4
    assign col_calc = {packet_reg[59:53], packet_reg[46]};
    assign row_calc = {packet_reg[52:47], packet_reg[45:44]};

    // raw timestamp: top sync bits, coarse, toa, inverted fine toa, 8 zero bits
    assign t_raw = {sync_reg[59:42], packet_reg[15:0], packet_reg[43:30],
                    ~packet_reg[19:16], 8'h00};
    assign t_ext = {3'b000, t_raw};

    // wrap correction: add ceil((diff - 2^41) / 2^42) steps of 2^42
    assign diff   = prev_reg - t_ext;
    assign behind = (prev_reg > t_ext) && (diff > phpd_pkg::HALF_WRAP);
    assign bump   = {1'b0, diff} + {1'b0, phpd_pkg::HALF_WRAP_M1};
    assign wraps  = behind ? bump[63:42] : 22'd0;
    assign upper  = {5'b00000, t_raw[59:42]} + {1'b0, wraps};

    // saturate when the sum reaches bit 63
    assign t_fin = (upper[22:21] != 2'b00) ? phpd_pkg::TIME_MAX
                                            : {upper[20:0], t_raw[41:0]};

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            packet_reg <= packet_word;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= phpd_pkg::STARTUP_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= startup_limit;
        end
    end

    // decoder state, updated as each packet leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg    <= '0;
            prev_reg    <= '0;
            started_reg <= 1'b0;
        end
        else if (advance)
        begin
            sync_reg    <= sync_next;
            started_reg <= started_next;
            if (is_hit)
            begin
                prev_reg <= t_fin;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && is_hit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_hit)
        begin
            col_reg  <= col_calc;
            row_reg  <= row_calc;
            tot_reg  <= packet_reg[29:20];
            time_reg <= t_fin;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit_column = col_reg;
    assign hit_row    = row_reg;
    assign tot_count  = tot_reg;
    assign hit_time   = time_reg;

endmodule

// File: rtl/phpd_checker.sv
`timescale 1ns / 1ps

module phpd_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [phpd_pkg::WORD_W-1:0]         packet_word,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [phpd_pkg::COL_W-1:0]          hit_column,
    input  logic [phpd_pkg::ROW_W-1:0]          hit_row,
    input  logic [phpd_pkg::TOT_W-1:0]          tot_count,
    input  logic [phpd_pkg::TIME_W-1:0]         hit_time
);

    // stalled hit holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit_column) && $stable(hit_row)
            && $stable(tot_count) && $stable(hit_time))
        else $error("stalled hit changed");

    // a fresh hit comes from an accepted pixel packet, through the input and result registers
    a_hit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2)
            && (($past(packet_word[63:60], 2) == phpd_pkg::HDR_PIXEL_A)
             || ($past(packet_word[63:60], 2) == phpd_pkg::HDR_PIXEL_B)))
        else $error("hit without pixel packet");

    // a taking receiver never stalls the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output drains");

    // timestamps carry eight zero low bits unless saturated
    a_time_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit_time[7:0] == 8'h00) || (hit_time == phpd_pkg::TIME_MAX))
        else $error("malformed hit time");

endmodule

bind pixel_hit_packet_decoder phpd_checker u_phpd_checker (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // run limits
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned STALL_LEN   = 200;   // long receiver hold-off
    localparam int unsigned DRAIN_GAP   = 6;     // heartbeat may still sit in the input stage
    localparam int unsigned PHASE_ITEMS = 160;

    // wrap correction, recomputed here in 64 bits
    localparam logic [63:0] WRAP_STEP   = 64'd1 << 42;
    localparam logic [63:0] WRAP_HALF   = 64'd1 << 41;
    localparam logic [63:0] STAMP_TOP   = {1'b0, {63{1'b1}}};

    // one decoded hit as it leaves the block
    typedef struct packed {
        logic [phpd_pkg::COL_W-1:0]  column;
        logic [phpd_pkg::ROW_W-1:0]  row;
        logic [phpd_pkg::TOT_W-1:0]  tot;
        logic [phpd_pkg::TIME_W-1:0] stamp;
    } hit_t;

    // what a row of the directed table does
    typedef enum logic [1:0] {
        ROW_CFG,    // drain, then write the limit held in the word field
        ROW_QUIET,  // packet that must give no hit
        ROW_TYPED,  // packet whose hit is written out in the table
        ROW_MODEL   // packet checked against the decoder model
    } row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [phpd_pkg::WORD_W-1:0] word;
        hit_t                        want;
    } plan_row_t;

    // directed walk: reset limit boundary, zero limit, a chosen limit hit
    // exactly and then from below, extremes of the pixel fields, the wrap
    // correction, garbage heartbeats and foreign headers
    localparam plan_row_t PLAN [27] = '{
        // limit still at its reset value: pixel before start, sync equal to limit
        '{ROW_QUIET, 64'hA000_0000_0000_0000, '0},
        '{ROW_QUIET, 64'h4400_0E4E_1C00_0000, '0},
        '{ROW_QUIET, 64'h4500_0000_0000_0000, '0},
        '{ROW_QUIET, 64'hBFFF_FFFF_FFFF_FFFF, '0},
        // zero limit: nothing is ever below it
        '{ROW_CFG,   64'h0000_0000_0000_0000, '0},
        '{ROW_QUIET, 64'h4400_0000_0000_0000, '0},
        '{ROW_QUIET, 64'h4500_0000_0000_0000, '0},
        '{ROW_QUIET, 64'hA000_0000_0000_0000, '0},
        // chosen limit: equal does not start, one step below does on the high beat
        '{ROW_CFG,   64'h0000_0012_3456_7000, '0},
        '{ROW_QUIET, 64'h4400_0123_4567_0000, '0},
        '{ROW_QUIET, 64'h4500_0000_0000_0000, '0},
        '{ROW_QUIET, 64'h4400_0123_4566_0000, '0},
        '{ROW_QUIET, 64'hA000_0000_0000_0000, '0},   // low beat alone does not arm
        '{ROW_QUIET, 64'h4500_0000_0000_0000, '0},
        // started: all-zero and all-one pixel payloads
        '{ROW_TYPED, 64'hA000_0000_0000_0000, '{8'h00, 8'h00, 10'h000, 63'h0F00}},
        '{ROW_TYPED, 64'hBFFF_FFFF_FFFF_FFFF,
                     '{8'hFF, 8'hFF, 10'h3FF, 63'h3FF_FFFF_F000}},
        '{ROW_MODEL, 64'hA000_0000_0000_0000, '0},   // far behind, one wrap step
        // ignored packets
        '{ROW_QUIET, 64'h4501_0000_FFFF_0000, '0},   // heartbeat with nonzero middle
        '{ROW_QUIET, 64'h4700_FFFF_FFFF_FFFF, '0},   // unknown sub-header
        '{ROW_QUIET, 64'h0FFF_FFFF_FFFF_FFFF, '0},
        '{ROW_QUIET, 64'hFFFF_FFFF_FFFF_FFFF, '0},
        // upper sync half at its maximum, then back to zero for a many-step wrap
        '{ROW_QUIET, 64'h4500_0000_FFFF_0000, '0},
        '{ROW_MODEL, 64'hB123_4567_89AB_CDEF, '0},
        '{ROW_QUIET, 64'h4500_0000_0000_0000, '0},
        '{ROW_MODEL, 64'hA000_0000_0000_0000, '0},
        // widest limit
        '{ROW_CFG,   64'h0FFF_FFFF_FFFF_FFFF, '0},
        '{ROW_MODEL, 64'hA55A_A55A_5AA5_5AA5, '0}
    };

    // dut ports, all inputs known from time zero
    logic                          clk            = 1'b0;
    logic                          rst_n          = 1'b0;
    logic                          cfg_wr_en      = 1'b0;
    logic [phpd_pkg::SYNC_W-1:0]   startup_limit  = phpd_pkg::STARTUP_LIMIT_RESET;
    logic                          in_valid       = 1'b0;
    logic                          in_ready;
    logic [phpd_pkg::WORD_W-1:0]   packet_word    = '0;
    logic                          out_valid;
    logic                          out_ready      = 1'b0;
    logic [phpd_pkg::COL_W-1:0]    hit_column;
    logic [phpd_pkg::ROW_W-1:0]    hit_row;
    logic [phpd_pkg::TOT_W-1:0]    tot_count;
    logic [phpd_pkg::TIME_W-1:0]   hit_time;

    // decoder model state
    logic [phpd_pkg::SYNC_W-1:0]   sync_model;
    logic [phpd_pkg::TIME_W-1:0]   last_stamp_model;
    logic                          started_model;
    logic [phpd_pkg::SYNC_W-1:0]   limit_model;

    hit_t                pending_hits [$];
    int unsigned         mismatch_count = 0;
    int unsigned         cycle_count    = 0;

    // idle rates in percent, and the long hold-off request counter
    int unsigned         in_idle_pct    = 0;
    int unsigned         out_idle_pct   = 0;
    int unsigned         hold_req       = 0;
    int unsigned         hold_seen      = 0;
    int unsigned         hold_left      = 0;

    pixel_hit_packet_decoder i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .startup_limit (startup_limit),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .packet_word   (packet_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hit_column    (hit_column),
        .hit_row       (hit_row),
        .tot_count     (tot_count),
        .hit_time      (hit_time)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // decode one packet into the model state; returns 1 when a hit comes out
    function automatic bit decode_packet(input logic [phpd_pkg::WORD_W-1:0] w,
                                         output hit_t h);
        logic [63:0] stamp;
        logic [63:0] behind;
        logic [63:0] steps;
        h = '0;
        if (w[63:60] == phpd_pkg::HDR_HEARTBEAT)
        begin
            if (w[55:48] != 8'd0)
                return 1'b0;
            if (w[59:56] == phpd_pkg::SUB_SYNC_LOW)
                sync_model = {sync_model[59:44], w[47:16], 12'd0};
            else if (w[59:56] == phpd_pkg::SUB_SYNC_HIGH)
            begin
                sync_model = {w[31:16], sync_model[43:0]};
                if (sync_model < limit_model)
                    started_model = 1'b1;
            end
            return 1'b0;
        end
        if (!started_model)
            return 1'b0;
        if (w[63:60] != phpd_pkg::HDR_PIXEL_A && w[63:60] != phpd_pkg::HDR_PIXEL_B)
            return 1'b0;
        // coarse, toa and inverted fine toa sit in disjoint bits, sync top above them
        stamp = {22'd0, w[15:0], w[43:30], 4'(4'd15 - w[19:16]), 8'd0}
              + {4'd0, sync_model[59:42], 42'd0};
        if ({1'b0, last_stamp_model} > stamp
            && {1'b0, last_stamp_model} - stamp > WRAP_HALF)
        begin
            behind = {1'b0, last_stamp_model} - stamp - WRAP_HALF;
            steps  = (behind + WRAP_STEP - 64'd1) >> 42;
            stamp  = stamp + (steps << 42);
        end
        if (stamp > STAMP_TOP)
            stamp = STAMP_TOP;
        last_stamp_model = stamp[phpd_pkg::TIME_W-1:0];
        h.column = {w[59:53], w[46]};
        h.row    = {w[52:47], w[45:44]};
        h.tot    = w[29:20];
        h.stamp  = stamp[phpd_pkg::TIME_W-1:0];
        return 1'b1;
    endfunction

    // mostly well-formed pixel packets and heartbeats with random content,
    // the rest raw noise, a share of it forced onto the heartbeat header as garbage heartbeats
    function automatic logic [phpd_pkg::WORD_W-1:0] random_packet();
        logic [phpd_pkg::WORD_W-1:0] w;
        int unsigned                 pick;
        w    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 60)
            w[63:60] = $urandom_range(1) ? phpd_pkg::HDR_PIXEL_A : phpd_pkg::HDR_PIXEL_B;
        else if (pick < 85)
        begin
            w[63:60] = phpd_pkg::HDR_HEARTBEAT;
            w[59:56] = $urandom_range(1) ? phpd_pkg::SUB_SYNC_LOW : phpd_pkg::SUB_SYNC_HIGH;
            w[55:48] = 8'd0;
        end
        else if (pick < 90)
            w[63:60] = phpd_pkg::HDR_HEARTBEAT;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // offer one packet, hold it until the transaction, then log the expectation
    task automatic send_packet(input logic [phpd_pkg::WORD_W-1:0] w, input row_kind_t kind,
                               input hit_t typed);
        hit_t h;
        bit   has_hit;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        packet_word <= w;
        do
            @(posedge clk);
        while (!in_ready);
        has_hit = decode_packet(w, h);
        if (kind == ROW_TYPED)
            pending_hits.push_back(typed);
        else if (kind == ROW_MODEL && has_hit)
            pending_hits.push_back(h);
    endtask

    // stop offering and let every pending hit come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_hits.size() != 0)
            @(posedge clk);
    endtask

    // the limit is only touched with nothing in flight
    task automatic write_limit(input logic [phpd_pkg::SYNC_W-1:0] value);
        wait_drained();
        repeat (DRAIN_GAP) @(posedge clk);
        cfg_wr_en     <= 1'b1;
        startup_limit <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        limit_model    = value;
    endtask

    task automatic run_random(input int unsigned in_pct, input int unsigned out_pct,
                              input bit long_hold, input bit sender_pause);
        in_idle_pct  = in_pct;
        out_idle_pct = out_pct;
        for (int unsigned n = 0; n < PHASE_ITEMS; n++)
        begin
            // receiver goes quiet while packets keep coming, so the block backs up
            if (long_hold && n == 10)
                hold_req <= hold_req + 1;
            // sender waits for an empty pipe once
            if (sender_pause && n == PHASE_ITEMS / 2)
                wait_drained();
            send_packet(random_packet(), ROW_MODEL, '0);
        end
    endtask

    // receiver side: random back-pressure plus the long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_seen <= 0;
            hold_left <= 0;
        end
        else if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= STALL_LEN;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // every output transaction against the oldest pending hit
    always @(posedge clk)
    begin : hit_check
        hit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hits.size() == 0)
                report_mismatch("hit with none pending",
                                64'({hit_column, hit_row, tot_count}), '0);
            else
            begin
                want = pending_hits.pop_front();
                if (hit_column !== want.column)
                    report_mismatch("hit_column", 64'(hit_column), 64'(want.column));
                if (hit_row !== want.row)
                    report_mismatch("hit_row", 64'(hit_row), 64'(want.row));
                if (tot_count !== want.tot)
                    report_mismatch("tot_count", 64'(tot_count), 64'(want.tot));
                if (hit_time !== want.stamp)
                    report_mismatch("hit_time", 64'(hit_time), 64'(want.stamp));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("pixel_hit_packet_decoder regression: fail");
            $finish;
        end
    end

    initial
    begin
        sync_model       = '0;
        last_stamp_model = '0;
        started_model    = 1'b0;
        limit_model      = phpd_pkg::STARTUP_LIMIT_RESET;
        in_idle_pct      = 34;
        out_idle_pct     = 48;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_CFG)
                write_limit(PLAN[i].word[phpd_pkg::SYNC_W-1:0]);
            else
                send_packet(PLAN[i].word, PLAN[i].kind, PLAN[i].want);
        end

        // random: sender idles more lightly, receiver heavier
        run_random(34, 48, 1'b0, 1'b0);
        write_limit('0);
        // swapped rates, with one pause of the sender until empty
        run_random(48, 34, 1'b0, 1'b1);
        write_limit(phpd_pkg::STARTUP_LIMIT_RESET);
        // full rate on both sides, with one long receiver hold-off
        run_random(0, 0, 1'b1, 1'b0);

        wait_drained();
        repeat (DRAIN_GAP) @(posedge clk);
        if (mismatch_count == 0)
            $display("pixel_hit_packet_decoder regression: pass");
        else
            $display("pixel_hit_packet_decoder regression: fail");
        $finish;
    end

endmodule
